// ===== rtl/core/cas_pkg.sv =====
// Package for the command-line argument splitter.
// Holds the scan mode type, character codes, result structs and helpers.
// No dependencies.
package cas_pkg;

    typedef enum logic [1:0] {
        MODE_BETWEEN = 2'd0,
        MODE_BARE    = 2'd1,
        MODE_DQUOTE  = 2'd2,
        MODE_SQUOTE  = 2'd3
    } mode_t;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;

    localparam int FIFO_DEPTH = 4;

    typedef struct packed {
        logic [7:0] ch;
        logic       has_char;
        logic       arg_end;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } dec_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic result_t char_res(input logic [7:0] c);
        result_t r;
        r.ch       = c;
        r.has_char = 1'b1;
        r.arg_end  = 1'b0;
        r.last     = 1'b0;
        return r;
    endfunction

    function automatic result_t end_res();
        result_t r;
        r.ch       = 8'd0;
        r.has_char = 1'b0;
        r.arg_end  = 1'b1;
        r.last     = 1'b0;
        return r;
    endfunction

endpackage

// ===== rtl/core/cas_decode.sv =====
// Scan state machine of the argument splitter: mode and escape registers,
// plus the decode of one byte into up to two result beats.
// Depends on cas_pkg.
module cas_decode (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           step,
    input  logic [7:0]     in_char,
    input  logic           end_of_text,
    output cas_pkg::dec_t  dec
);

    cas_pkg::mode_t mode_reg, mode_next;
    logic           esc_reg, esc_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= cas_pkg::MODE_BETWEEN;
            esc_reg  <= 1'b0;
        end else if (step) begin
            mode_reg <= mode_next;
            esc_reg  <= esc_next;
        end
    end

    always_comb begin
        mode_next = mode_reg;
        esc_next  = esc_reg;
        if (end_of_text) begin
            mode_next = cas_pkg::MODE_BETWEEN;
            esc_next  = 1'b0;
        end else begin
            unique case (mode_reg)
                cas_pkg::MODE_BETWEEN: begin
                    esc_next = 1'b0;
                    if (cas_pkg::is_space(in_char)) begin
                        mode_next = cas_pkg::MODE_BETWEEN;
                    end else if (in_char == cas_pkg::CH_DQUOTE) begin
                        mode_next = cas_pkg::MODE_DQUOTE;
                    end else if (in_char == cas_pkg::CH_SQUOTE) begin
                        mode_next = cas_pkg::MODE_SQUOTE;
                    end else begin
                        mode_next = cas_pkg::MODE_BARE;
                    end
                end
                cas_pkg::MODE_BARE: begin
                    if (cas_pkg::is_space(in_char)) begin
                        mode_next = cas_pkg::MODE_BETWEEN;
                    end
                end
                cas_pkg::MODE_DQUOTE: begin
                    if (esc_reg) begin
                        esc_next = 1'b0;
                    end else if (in_char == cas_pkg::CH_BACKSLASH) begin
                        esc_next = 1'b1;
                    end else if (in_char == cas_pkg::CH_DQUOTE) begin
                        mode_next = cas_pkg::MODE_BETWEEN;
                    end
                end
                cas_pkg::MODE_SQUOTE: begin
                    esc_next = 1'b0;
                    if (in_char == cas_pkg::CH_SQUOTE) begin
                        mode_next = cas_pkg::MODE_BETWEEN;
                    end
                end
                default: begin
                    mode_next = cas_pkg::MODE_BETWEEN;
                end
            endcase
        end
    end

    always_comb begin
        dec.count = 2'd0;
        dec.r0    = '0;
        dec.r1    = '0;
        if (end_of_text) begin
            if (mode_reg != cas_pkg::MODE_BETWEEN) begin
                dec.count = 2'd1;
                dec.r0    = cas_pkg::end_res();
            end
        end else begin
            unique case (mode_reg)
                cas_pkg::MODE_BETWEEN: begin
                    if (!cas_pkg::is_space(in_char) && in_char != cas_pkg::CH_DQUOTE
                            && in_char != cas_pkg::CH_SQUOTE) begin
                        dec.count = 2'd1;
                        dec.r0    = cas_pkg::char_res(in_char);
                    end
                end
                cas_pkg::MODE_BARE: begin
                    dec.count = 2'd1;
                    dec.r0    = cas_pkg::is_space(in_char) ? cas_pkg::end_res()
                                                           : cas_pkg::char_res(in_char);
                end
                cas_pkg::MODE_DQUOTE: begin
                    if (esc_reg) begin
                        if (in_char != cas_pkg::CH_BACKSLASH
                                && in_char != cas_pkg::CH_DQUOTE) begin
                            dec.count = 2'd2;
                            dec.r0    = cas_pkg::char_res(cas_pkg::CH_BACKSLASH);
                            dec.r1    = cas_pkg::char_res(in_char);
                        end else begin
                            dec.count = 2'd1;
                            dec.r0    = cas_pkg::char_res(in_char);
                        end
                    end else if (in_char == cas_pkg::CH_DQUOTE) begin
                        dec.count = 2'd1;
                        dec.r0    = cas_pkg::end_res();
                    end else if (in_char != cas_pkg::CH_BACKSLASH) begin
                        dec.count = 2'd1;
                        dec.r0    = cas_pkg::char_res(in_char);
                    end
                end
                cas_pkg::MODE_SQUOTE: begin
                    dec.count = 2'd1;
                    dec.r0    = (in_char == cas_pkg::CH_SQUOTE) ? cas_pkg::end_res()
                                                                : cas_pkg::char_res(in_char);
                end
                default: begin
                    dec.count = 2'd0;
                end
            endcase
        end
        dec.r0.last = (dec.count == 2'd1);
        dec.r1.last = (dec.count == 2'd2);
    end

endmodule

// ===== rtl/core/cas_out_fifo.sv =====
// Result queue of the argument splitter: takes zero, one or two result
// beats per cycle and drives the master stream. Depends on cas_pkg.
module cas_out_fifo #(
    parameter int DEPTH = cas_pkg::FIFO_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cas_pkg::dec_t     dec,
    input  logic              push,
    output logic              room,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // out_char
    output logic [1:0]        m_tuser,   // has_char, arg_end
    output logic              m_tlast    // last
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    cas_pkg::result_t mem [DEPTH];

    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg, wr_ptr1;
    logic [CW-1:0] cnt_reg, cnt_next, cnt_after_pop, push_n;
    logic          pop;
    cas_pkg::result_t head;

    assign pop           = m_tvalid && m_tready;
    assign cnt_after_pop = cnt_reg - CW'(pop);
    assign room          = cnt_after_pop <= CW'(DEPTH - 2);
    assign push_n        = push ? CW'(dec.count) : '0;
    assign cnt_next      = cnt_after_pop + push_n;
    assign wr_ptr1       = wr_ptr_reg + PW'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + PW'(push_n);
            rd_ptr_reg <= rd_ptr_reg + PW'(pop);
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push && dec.count != 2'd0) begin
            mem[wr_ptr_reg] <= dec.r0;
        end
        if (push && dec.count == 2'd2) begin
            mem[wr_ptr1] <= dec.r1;
        end
    end

    assign head     = mem[rd_ptr_reg];
    assign m_tvalid = cnt_reg != '0;
    assign m_tdata  = head.ch;
    assign m_tuser  = {head.arg_end, head.has_char};
    assign m_tlast  = head.last;

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(DEPTH))
        else $error("result queue count beyond depth");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> room)
        else $error("push into result queue without room");

    a_cnt_track: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> cnt_reg == $past(cnt_reg) - CW'($past(pop)) + $past(push_n))
        else $error("result queue count out of step");

    a_beat_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("result beat carries both a byte and an argument end");

endmodule

// ===== rtl/core/cmdline_argument_splitter.sv =====
// Command-line argument splitter, top level.
// Input register, scan decoder and result queue. Depends on cas_pkg,
// cas_decode and cas_out_fifo.
//
// Usage:
//   Slave stream: one text byte per beat in s_tdata; s_tlast marks end of
//   text, in which case s_tdata is ignored and the splitter returns to the
//   between-arguments state.
//   Master stream: each beat is an argument byte (m_tuser[0]) or an
//   argument end mark (m_tuser[1]); m_tlast flags the last beat caused by
//   one input beat. Input beats that only change state give no beat.
//   Path: each input beat is held in the input register, then its result
//   beats are written to the queue, from which the master stream reads.
//   Throughput: one input beat per cycle while the queue has room; an
//   escape that yields two bytes gives two output beats, read out one by
//   one through the single read port of the result queue.
//   Reset: aresetn low, synchronous; queue and input register empty, scan
//   state between arguments.
//   Stall: with m_tready low the queue fills until it lacks room for two
//   beats; then the input register fills, s_tready drops; nothing is lost.
module cmdline_argument_splitter #(
    parameter int FIFO_DEPTH = cas_pkg::FIFO_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_char
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_char
    output logic [1:0]  m_tuser,   // has_char, arg_end
    output logic        m_tlast    // last
);

    logic          in_valid_reg;
    logic [7:0]    in_char_reg;
    logic          in_eot_reg;
    logic          room;
    logic          step;
    cas_pkg::dec_t dec;

    assign step     = in_valid_reg && room;
    assign s_tready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_char_reg <= s_tdata;
            in_eot_reg  <= s_tlast;
        end
    end

    cas_decode u_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .in_char     (in_char_reg),
        .end_of_text (in_eot_reg),
        .dec         (dec)
    );

    cas_out_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_out_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .dec      (dec),
        .push     (step),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for cmdline_argument_splitter.
// Drives text beats (directed table, then weighted random text) and checks each result beat
// against a built-in tokenizer model or typed table rows. Depends on cas_pkg and the RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_DIRECTED   = 26;
    localparam int RANDOM_ITEMS = 1425;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 100;
    localparam int LONG_HOLD    = 300;

    // result_t is {ch, has_char, arg_end, last}
    localparam cas_pkg::result_t NO_BEAT  = '0;
    localparam cas_pkg::result_t END_LAST = {8'h00, 1'b0, 1'b1, 1'b1};

    typedef struct {
        logic [7:0]       ch;
        logic             eot;
        bit               typed;
        int unsigned      n;
        cas_pkg::result_t r0;
        cas_pkg::result_t r1;
    } stim_row_t;

    logic       aclk;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // in_char
    logic       s_tlast  = 1'b0;    // end_of_text
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // out_char
    logic [1:0] m_tuser;            // has_char, arg_end
    logic       m_tlast;            // last

    cas_pkg::mode_t   scan_state = cas_pkg::MODE_BETWEEN;
    logic             esc_seen   = 1'b0;
    cas_pkg::result_t step_beats[$];
    cas_pkg::result_t pending_beats[$];
    stim_row_t        directed_rows [N_DIRECTED];

    bit          steady       = 1'b0;
    bit          hold_off_req = 1'b0;
    int unsigned errors       = 0;
    int unsigned items_sent   = 0;
    int unsigned beats_seen   = 0;
    int unsigned args_seen    = 0;
    int unsigned cycle_count  = 0;

    cmdline_argument_splitter i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic logic blank(input logic [7:0] c);
        return (c == cas_pkg::CH_SPACE) || (c >= cas_pkg::CH_TAB && c <= cas_pkg::CH_CR);
    endfunction

    function automatic cas_pkg::result_t beat(input logic [7:0] c, input logic has,
                                              input logic fin);
        return {has ? c : 8'h00, has, fin, 1'b0};
    endfunction

    // Advance the tokenizer state by one text beat; fills step_beats.
    task automatic tokenize_step(input logic [7:0] c, input logic eot);
        step_beats = {};
        if (eot) begin
            if (scan_state != cas_pkg::MODE_BETWEEN)
                step_beats.push_back(beat(8'h00, 1'b0, 1'b1));
            scan_state = cas_pkg::MODE_BETWEEN;
            esc_seen = 1'b0;
        end else begin
            case (scan_state)
                cas_pkg::MODE_BETWEEN: begin
                    esc_seen = 1'b0;
                    if (!blank(c)) begin
                        if (c == cas_pkg::CH_DQUOTE) begin
                            scan_state = cas_pkg::MODE_DQUOTE;
                        end else if (c == cas_pkg::CH_SQUOTE) begin
                            scan_state = cas_pkg::MODE_SQUOTE;
                        end else begin
                            scan_state = cas_pkg::MODE_BARE;
                            step_beats.push_back(beat(c, 1'b1, 1'b0));
                        end
                    end
                end
                cas_pkg::MODE_BARE: begin
                    if (blank(c)) begin
                        step_beats.push_back(beat(8'h00, 1'b0, 1'b1));
                        scan_state = cas_pkg::MODE_BETWEEN;
                    end else begin
                        step_beats.push_back(beat(c, 1'b1, 1'b0));
                    end
                end
                cas_pkg::MODE_DQUOTE: begin
                    if (esc_seen) begin
                        esc_seen = 1'b0;
                        if (c != cas_pkg::CH_BACKSLASH && c != cas_pkg::CH_DQUOTE)
                            step_beats.push_back(beat(cas_pkg::CH_BACKSLASH, 1'b1, 1'b0));
                        step_beats.push_back(beat(c, 1'b1, 1'b0));
                    end else if (c == cas_pkg::CH_BACKSLASH) begin
                        esc_seen = 1'b1;
                    end else if (c == cas_pkg::CH_DQUOTE) begin
                        step_beats.push_back(beat(8'h00, 1'b0, 1'b1));
                        scan_state = cas_pkg::MODE_BETWEEN;
                    end else begin
                        step_beats.push_back(beat(c, 1'b1, 1'b0));
                    end
                end
                default: begin
                    esc_seen = 1'b0;
                    if (c == cas_pkg::CH_SQUOTE) begin
                        step_beats.push_back(beat(8'h00, 1'b0, 1'b1));
                        scan_state = cas_pkg::MODE_BETWEEN;
                    end else begin
                        step_beats.push_back(beat(c, 1'b1, 1'b0));
                    end
                end
            endcase
        end
        if (step_beats.size() > 0) step_beats[step_beats.size() - 1].last = 1'b1;
    endtask

    // Offer one text beat until taken, then queue what it should produce.
    task automatic push_item(input logic [7:0] c, input logic eot, input bit typed,
                             input int unsigned n, input cas_pkg::result_t r0,
                             input cas_pkg::result_t r1);
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eot;
        do @(posedge aclk); while (s_tready !== 1'b1);
        tokenize_step(c, eot);
        if (typed) begin
            step_beats = {};
            if (n > 0) step_beats.push_back(r0);
            if (n > 1) step_beats.push_back(r1);
        end
        foreach (step_beats[k]) pending_beats.push_back(step_beats[k]);
        items_sent++;
    endtask

    task automatic sender_gap();
        int unsigned g;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) g = 0;
        else if (r < 90) g = $urandom_range(1, 3);
        else g = $urandom_range(4, 25);
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    function automatic logic [7:0] pick_char();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            r = $urandom_range(0, 5);
            return (r == 5) ? cas_pkg::CH_SPACE : cas_pkg::CH_TAB + 8'(r);
        end
        if (r < 25) return cas_pkg::CH_DQUOTE;
        if (r < 33) return cas_pkg::CH_SQUOTE;
        if (r < 45) return cas_pkg::CH_BACKSLASH;
        if (r < 75) return 8'($urandom_range(8'h21, 8'h7E));
        return 8'($urandom_range(0, 255));
    endfunction

    // Receiver: random back-pressure and beat checking.
    initial begin
        int unsigned hold;
        int unsigned r;
        cas_pkg::result_t exp_beat;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid === 1'b1 && m_tready) begin
                beats_seen++;
                if (pending_beats.size() == 0) begin
                    $error("unexpected beat: out_char %h user %b last %b",
                           m_tdata, m_tuser, m_tlast);
                    errors++;
                end else begin
                    exp_beat = pending_beats.pop_front();
                    if (exp_beat.arg_end) args_seen++;
                    if (m_tdata !== exp_beat.ch) begin
                        $error("out_char: expected %h, got %h", exp_beat.ch, m_tdata);
                        errors++;
                    end
                    if (m_tuser[0] !== exp_beat.has_char) begin
                        $error("has_char: expected %b, got %b", exp_beat.has_char, m_tuser[0]);
                        errors++;
                    end
                    if (m_tuser[1] !== exp_beat.arg_end) begin
                        $error("arg_end: expected %b, got %b", exp_beat.arg_end, m_tuser[1]);
                        errors++;
                    end
                    if (m_tlast !== exp_beat.last) begin
                        $error("last: expected %b, got %b", exp_beat.last, m_tlast);
                        errors++;
                    end
                end
            end
            if (hold_off_req) begin
                hold = LONG_HOLD;
                hold_off_req = 1'b0;
            end
            if (hold > 0) begin
                m_tready <= 1'b0;
                hold--;
            end else if (steady) begin
                m_tready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 65) begin
                    m_tready <= 1'b1;
                end else begin
                    m_tready <= 1'b0;
                    hold = (r < 93) ? $urandom_range(0, 2) : $urandom_range(5, 30);
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        int unsigned k;
        logic [7:0] c;
        logic eot;
        directed_rows = '{
            '{8'hFF,                 1'b1, 1'b1, 0, NO_BEAT, NO_BEAT},  // end of text between args
            '{8'h00,                 1'b0, 1'b1, 1, {8'h00, 1'b1, 1'b0, 1'b1}, NO_BEAT},
            '{8'hFF,                 1'b0, 1'b1, 1, {8'hFF, 1'b1, 1'b0, 1'b1}, NO_BEAT},
            '{cas_pkg::CH_SPACE,     1'b0, 1'b1, 1, END_LAST, NO_BEAT},
            '{cas_pkg::CH_DQUOTE,    1'b0, 1'b0, 0, NO_BEAT, NO_BEAT},
            '{cas_pkg::CH_DQUOTE,    1'b0, 1'b1, 1, END_LAST, NO_BEAT},  // empty quoted arg
            '{cas_pkg::CH_SQUOTE,    1'b0, 1'b0, 0, NO_BEAT, NO_BEAT},
            '{cas_pkg::CH_BACKSLASH, 1'b0, 1'b0, 0, NO_BEAT, NO_BEAT},
            '{cas_pkg::CH_DQUOTE,    1'b0, 1'b0, 0, NO_BEAT, NO_BEAT},
            '{cas_pkg::CH_SQUOTE,    1'b0, 1'b0, 0, NO_BEAT, NO_BEAT},
            '{cas_pkg::CH_DQUOTE,    1'b0, 1'b0, 0, NO_BEAT, NO_BEAT},
            '{cas_pkg::CH_BACKSLASH, 1'b0, 1'b0, 0, NO_BEAT, NO_BEAT},
            '{cas_pkg::CH_BACKSLASH, 1'b0, 1'b0, 0, NO_BEAT, NO_BEAT},
            '{cas_pkg::CH_BACKSLASH, 1'b0, 1'b0, 0, NO_BEAT, NO_BEAT},
            '{cas_pkg::CH_DQUOTE,    1'b0, 1'b0, 0, NO_BEAT, NO_BEAT},
            '{cas_pkg::CH_BACKSLASH, 1'b0, 1'b0, 0, NO_BEAT, NO_BEAT},
            '{8'h6E,                 1'b0, 1'b0, 0, NO_BEAT, NO_BEAT},  // other escape: two beats
            '{cas_pkg::CH_TAB,       1'b0, 1'b0, 0, NO_BEAT, NO_BEAT},
            '{cas_pkg::CH_BACKSLASH, 1'b0, 1'b0, 0, NO_BEAT, NO_BEAT},
            '{8'h00,                 1'b1, 1'b1, 1, END_LAST, NO_BEAT},  // trailing backslash dropped
            '{cas_pkg::CH_SQUOTE,    1'b0, 1'b0, 0, NO_BEAT, NO_BEAT},
            '{8'h5A,                 1'b1, 1'b1, 1, END_LAST, NO_BEAT},  // unterminated quote
            '{8'h61,                 1'b0, 1'b0, 0, NO_BEAT, NO_BEAT},
            '{cas_pkg::CH_CR,        1'b0, 1'b0, 0, NO_BEAT, NO_BEAT},
            '{8'h0B,                 1'b0, 1'b0, 0, NO_BEAT, NO_BEAT},
            '{8'hA5,                 1'b1, 1'b1, 0, NO_BEAT, NO_BEAT}
        };
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            push_item(directed_rows[i].ch, directed_rows[i].eot, directed_rows[i].typed,
                      directed_rows[i].n, directed_rows[i].r0, directed_rows[i].r1);
            sender_gap();
        end

        for (k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == 300) hold_off_req = 1'b1;
            if (k == 700) begin
                s_tvalid <= 1'b0;
                do @(posedge aclk); while (pending_beats.size() != 0);
            end
            steady = (k >= 900 && k < 1000);
            c = pick_char();
            eot = ($urandom_range(0, 99) < 3);
            push_item(c, eot, 1'b0, 0, NO_BEAT, NO_BEAT);
            sender_gap();
        end
        s_tvalid <= 1'b0;

        while (pending_beats.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d text beats (%0d from the directed table), checked %0d result beats",
                 items_sent, N_DIRECTED, beats_seen);
        $display("covering %0d completed arguments, with stalls on both sides", args_seen);
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule

// ===== files.f =====
rtl/core/cas_pkg.sv
rtl/core/cas_decode.sv
rtl/core/cas_out_fifo.sv
rtl/core/cmdline_argument_splitter.sv
tb/testbench.sv
